>>> rtl/ktp_pkg.sv
// package with types, constants and register codes for the keyframe transform player
package ktp_pkg;

  localparam int unsigned NumComp       = 9;
  localparam int unsigned CompWidth     = 32;
  localparam int unsigned DefMaxKeys    = 16;
  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned FcWidth       = 17;
  localparam int unsigned KeyIdxWidth   = 4;
  localparam int unsigned KeyFrameWidth = 16;
  localparam int unsigned KeyCountWidth = 5;
  localparam int unsigned PeriodWidth   = 16;
  localparam int unsigned PaddrWidth    = 3;

  localparam logic [PaddrWidth-1:0] AddrKeyCount = 3'd0;
  localparam logic [PaddrWidth-1:0] AddrPeriod   = 3'd4;

  localparam logic [KeyCountWidth-1:0] KeyCountReset = 5'd1;
  localparam logic [PeriodWidth-1:0]   PeriodReset   = 16'd16;

  typedef enum logic [1:0] {
    KindTick    = 2'd0,
    KindLoad    = 2'd1,
    KindRestart = 2'd2,
    KindMarkEnd = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PhWaiting  = 2'd0,
    PhRunning  = 2'd1,
    PhEnding   = 2'd2,
    PhFinished = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDiv,
    StApply,
    StFinish,
    StOut
  } state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic [KeyIdxWidth-1:0]   key_index;
    logic [KeyFrameWidth-1:0] key_frame;
    logic signed [CompWidth-1:0] pos_x;
    logic signed [CompWidth-1:0] pos_y;
    logic signed [CompWidth-1:0] pos_z;
    logic signed [CompWidth-1:0] rot_x;
    logic signed [CompWidth-1:0] rot_y;
    logic signed [CompWidth-1:0] rot_z;
    logic signed [CompWidth-1:0] scale_x;
    logic signed [CompWidth-1:0] scale_y;
    logic signed [CompWidth-1:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CompWidth-1:0] out_pos_x;
    logic signed [CompWidth-1:0] out_pos_y;
    logic signed [CompWidth-1:0] out_pos_z;
    logic signed [CompWidth-1:0] out_rot_x;
    logic signed [CompWidth-1:0] out_rot_y;
    logic signed [CompWidth-1:0] out_rot_z;
    logic signed [CompWidth-1:0] out_scale_x;
    logic signed [CompWidth-1:0] out_scale_y;
    logic signed [CompWidth-1:0] out_scale_z;
    logic [1:0]                  play_state;
    logic                        stepped;
  } out_item_t;

endpackage

>>> rtl/keyframe_transform_player.sv
// top level of the keyframe transform player with sequencer and apb registers
// usage:
//   in channel (in_valid_i/in_ready_o/in_item_i) takes tick, load, restart and
//   mark-end items; out channel (out_valid_o/out_ready_i/out_item_o) returns
//   exactly one result per item.
//   apb port sets key_count (0x0) and frame_period_ms (0x4); pready is always high.
//   restart, mark-end and non-stepping ticks go from the read state straight
//   to the output state; a load with a valid key index first makes nine table
//   writes, and a step on a reached key passes the divide and finish states
//   without a divide. a tick with a frame step runs the nine components one
//   after another through one shared bit-serial divider of VALUE_WIDTH + 2 quotient bits.
//   one item is handled at a time; in_ready_o is low from acceptance until the
//   cycle after the result transfer, so a stalled receiver holds the block.
//   reset clears the phase, counters and offsets and loads register defaults;
//   the key table is undefined until loaded.
module keyframe_transform_player #(
  parameter int unsigned MaxKeys    = ktp_pkg::DefMaxKeys,
  parameter int unsigned ValueWidth = ktp_pkg::DefValueWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ktp_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ktp_pkg::out_item_t   out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ktp_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned NC    = ktp_pkg::NumComp;
  localparam int unsigned KW    = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
  localparam int unsigned TDep  = MaxKeys * NC;
  localparam int unsigned TAW   = $clog2(TDep);
  localparam int unsigned FcW   = ktp_pkg::FcWidth;
  localparam int unsigned NumW  = ValueWidth + 2;
  localparam int unsigned DenW  = FcW + 1;
  localparam int unsigned CW    = 4;
  localparam int unsigned CompW = ktp_pkg::CompWidth;
  localparam int unsigned KcW   = ktp_pkg::KeyCountWidth;
  localparam int unsigned PerW  = ktp_pkg::PeriodWidth;

  ktp_pkg::state_e state_q, state_d;
  ktp_pkg::phase_e phase_q, phase_d;

  ktp_pkg::in_item_t  item_q;
  ktp_pkg::out_item_t res_q;

  logic [KcW-1:0]  key_count_q;
  logic [PerW-1:0] period_q;
  logic [FcW-1:0]  fc_q, fc_d;
  logic [KW-1:0]   nk_q, nk_d;
  logic [PerW-1:0] ticks_q, ticks_d;
  logic [CW-1:0]   comp_q, comp_d;
  logic            out_valid_q, out_valid_d;
  logic            stepped_q, stepped_d;
  logic            rd_wait_q, rd_wait_d;
  logic [ValueWidth-1:0] off_q [NC];
  logic [ValueWidth-1:0] tr_q  [NC];

  // apb
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr)
      ktp_pkg::AddrKeyCount: prdata = 32'(key_count_q);
      ktp_pkg::AddrPeriod:   prdata = 32'(period_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= ktp_pkg::KeyCountReset;
      period_q    <= ktp_pkg::PeriodReset;
    end else if (cfg_we) begin
      unique case (paddr)
        ktp_pkg::AddrKeyCount: key_count_q <= pwdata[KcW-1:0];
        ktp_pkg::AddrPeriod:   period_q    <= pwdata[PerW-1:0];
        default: ;
      endcase
    end
  end

  // effective key count minus one
  logic [KcW:0] eff_last;
  always_comb begin
    if (key_count_q == '0) begin
      eff_last = '0;
    end else if ({1'b0, key_count_q} > (KcW+1)'(MaxKeys)) begin
      eff_last = (KcW+1)'(MaxKeys - 1);
    end else begin
      eff_last = {1'b0, key_count_q} - 1'b1;
    end
  end

  // key tables
  logic [ValueWidth-1:0] in_comp [NC];
  assign in_comp[0] = ValueWidth'(item_q.pos_x);
  assign in_comp[1] = ValueWidth'(item_q.pos_y);
  assign in_comp[2] = ValueWidth'(item_q.pos_z);
  assign in_comp[3] = ValueWidth'(item_q.rot_x);
  assign in_comp[4] = ValueWidth'(item_q.rot_y);
  assign in_comp[5] = ValueWidth'(item_q.rot_z);
  assign in_comp[6] = ValueWidth'(item_q.scale_x);
  assign in_comp[7] = ValueWidth'(item_q.scale_y);
  assign in_comp[8] = ValueWidth'(item_q.scale_z);

  logic                  tgt_we, kf_we;
  logic [TAW-1:0]        tgt_waddr, tgt_raddr;
  logic [ValueWidth-1:0] tgt_wdata, tgt_rdata;
  logic [ktp_pkg::KeyFrameWidth-1:0] kf_rdata;
  logic [KW-1:0]         load_slot;
  logic                  slot_ok;
  logic [KW+CW:0]        slot_base;

  assign slot_ok   = (32'(item_q.key_index) < MaxKeys);
  assign load_slot = KW'(item_q.key_index);
  assign slot_base = (KW+CW+1)'(load_slot) * (KW+CW+1)'(NC) + (KW+CW+1)'(comp_q);
  assign tgt_waddr = TAW'(slot_base);
  assign tgt_wdata = in_comp[comp_q];
  assign tgt_raddr = TAW'((KW+CW+1)'(nk_q) * (KW+CW+1)'(NC) + (KW+CW+1)'(comp_q));

  ktp_ram #(.Width(ValueWidth), .Depth(TDep)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (tgt_waddr),
    .wdata_i (tgt_wdata),
    .raddr_i (tgt_raddr),
    .rdata_o (tgt_rdata)
  );

  ktp_ram #(.Width(ktp_pkg::KeyFrameWidth), .Depth(MaxKeys)) u_kf_ram (
    .clk_i   (clk_i),
    .we_i    (kf_we),
    .waddr_i (load_slot),
    .wdata_i (item_q.key_frame),
    .raddr_i (nk_q),
    .rdata_o (kf_rdata)
  );

  // divider
  logic                   div_start, div_done;
  logic signed [NumW-1:0] div_num, div_quo;
  logic signed [DenW-1:0] left;
  logic signed [NumW-1:0] tgt_s, off_s;

  assign left    = $signed({1'b0, 1'b0, kf_rdata}) - $signed({1'b0, fc_q});
  assign tgt_s   = NumW'($signed(tgt_rdata));
  assign off_s   = NumW'($signed(off_q[comp_q]));
  assign div_num = tgt_s - off_s;

  ktp_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (left),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic [ValueWidth-1:0] delta;
  assign delta = div_quo[ValueWidth-1:0];

  logic in_fire, out_fire, last_comp;
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign last_comp = (comp_q == CW'(NC - 1));
  assign in_ready_o  = (state_q == ktp_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  logic [PerW-1:0] ticks_inc;
  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ktp_pkg::StIdle: if (in_fire) state_d = ktp_pkg::StRead;
      ktp_pkg::StRead: begin
        if (item_q.kind == ktp_pkg::KindLoad) begin
          if (!slot_ok || last_comp) state_d = ktp_pkg::StOut;
        end else if (item_q.kind == ktp_pkg::KindTick) begin
          if (phase_q != ktp_pkg::PhFinished && ticks_inc > period_q) begin
            state_d = ktp_pkg::StDiv;
          end else begin
            state_d = ktp_pkg::StOut;
          end
        end else begin
          state_d = ktp_pkg::StOut;
        end
      end
      ktp_pkg::StDiv: begin
        if (rd_wait_q) begin
          state_d = ktp_pkg::StDiv;
        end else if (left == '0) begin
          state_d = ktp_pkg::StFinish;
        end else begin
          state_d = ktp_pkg::StApply;
        end
      end
      ktp_pkg::StApply: begin
        if (div_done) state_d = last_comp ? ktp_pkg::StFinish : ktp_pkg::StDiv;
      end
      ktp_pkg::StFinish: state_d = ktp_pkg::StOut;
      ktp_pkg::StOut: if (out_fire) state_d = ktp_pkg::StIdle;
      default: state_d = ktp_pkg::StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_d     = phase_q;
    fc_d        = fc_q;
    nk_d        = nk_q;
    ticks_d     = ticks_q;
    comp_d      = comp_q;
    out_valid_d = out_valid_q;
    stepped_d   = stepped_q;
    rd_wait_d   = rd_wait_q;
    tgt_we      = 1'b0;
    kf_we       = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      ktp_pkg::StIdle: begin
        comp_d    = '0;
        stepped_d = 1'b0;
      end
      ktp_pkg::StRead: begin
        unique case (item_q.kind)
          ktp_pkg::KindLoad: begin
            tgt_we = slot_ok;
            kf_we  = slot_ok;
            comp_d = comp_q + 1'b1;
          end
          ktp_pkg::KindTick: begin
            ticks_d = ticks_inc;
            if (phase_q != ktp_pkg::PhFinished && ticks_inc > period_q) begin
              ticks_d   = '0;
              stepped_d = 1'b1;
              rd_wait_d = 1'b1;
              if (phase_q == ktp_pkg::PhWaiting) phase_d = ktp_pkg::PhRunning;
            end
          end
          ktp_pkg::KindRestart: begin
            fc_d    = '0;
            nk_d    = '0;
            ticks_d = '0;
            phase_d = ktp_pkg::PhWaiting;
          end
          default: begin
            if (phase_q == ktp_pkg::PhRunning) phase_d = ktp_pkg::PhEnding;
          end
        endcase
        if (state_d == ktp_pkg::StOut) out_valid_d = 1'b1;
      end
      ktp_pkg::StDiv: begin
        rd_wait_d = 1'b0;
        if (!rd_wait_q && left != '0) div_start = 1'b1;
      end
      ktp_pkg::StApply: begin
        if (div_done) begin
          comp_d    = comp_q + 1'b1;
          rd_wait_d = 1'b1;
        end
      end
      ktp_pkg::StFinish: begin
        if (left == '0) begin
          if ((KcW+1)'(nk_q) < eff_last) begin
            nk_d = nk_q + 1'b1;
            fc_d = fc_q + 1'b1;
          end else begin
            nk_d = '0;
            fc_d = '0;
            if (phase_q == ktp_pkg::PhEnding) phase_d = ktp_pkg::PhFinished;
          end
        end else begin
          fc_d = fc_q + 1'b1;
        end
        out_valid_d = 1'b1;
      end
      ktp_pkg::StOut: if (out_fire) out_valid_d = 1'b0;
      default: ;
    endcase
  end

  // offsets and transform
  logic wrap_clear;
  assign wrap_clear = (state_q == ktp_pkg::StFinish) && (left == '0) &&
                      !((KcW+1)'(nk_q) < eff_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NC; i++) off_q[i] <= '0;
    end else if ((state_q == ktp_pkg::StRead && item_q.kind == ktp_pkg::KindRestart)
                 || wrap_clear) begin
      for (int i = 0; i < NC; i++) off_q[i] <= '0;
    end else if (state_q == ktp_pkg::StApply && div_done) begin
      off_q[comp_q] <= off_q[comp_q] + delta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (state_q == ktp_pkg::StRead) begin
      for (int i = 0; i < NC; i++) begin
        tr_q[i] <= (item_q.kind == ktp_pkg::KindTick) ? in_comp[i] : '0;
      end
    end else if (state_q == ktp_pkg::StApply && div_done) begin
      tr_q[comp_q] <= tr_q[comp_q] + delta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ktp_pkg::StIdle;
      phase_q     <= ktp_pkg::PhWaiting;
      fc_q        <= '0;
      nk_q        <= '0;
      ticks_q     <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
      stepped_q   <= 1'b0;
      rd_wait_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fc_q        <= fc_d;
      nk_q        <= nk_d;
      ticks_q     <= ticks_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
      stepped_q   <= stepped_d;
      rd_wait_q   <= rd_wait_d;
    end
  end

  always_comb begin
    res_q.out_pos_x   = CompW'($signed(tr_q[0]));
    res_q.out_pos_y   = CompW'($signed(tr_q[1]));
    res_q.out_pos_z   = CompW'($signed(tr_q[2]));
    res_q.out_rot_x   = CompW'($signed(tr_q[3]));
    res_q.out_rot_y   = CompW'($signed(tr_q[4]));
    res_q.out_rot_z   = CompW'($signed(tr_q[5]));
    res_q.out_scale_x = CompW'($signed(tr_q[6]));
    res_q.out_scale_y = CompW'($signed(tr_q[7]));
    res_q.out_scale_z = CompW'($signed(tr_q[8]));
    res_q.play_state  = phase_q;
    res_q.stepped     = stepped_q;
  end
  assign out_item_o = res_q;

endmodule

>>> rtl/ktp_ram.sv
// generic single-port-write ram with registered read
module ktp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/ktp_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module ktp_div #(
  parameter int unsigned NumW = 34,
  parameter int unsigned DenW = 18
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  output logic                   done_o,
  output logic signed [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_o = 1'b0;
    trial  = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i[NumW-1] ? NumW'(-num_i) : num_i;
      den_d  = den_i[DenW-1] ? DenW'(-den_i) : den_i;
      neg_d  = num_i[NumW-1] ^ den_i[DenW-1];
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (!trial[DenW]) begin
          rem_d = trial[DenW-1:0];
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DenW-2:0], quo_q[NumW-1]};
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  assign quo_o = neg_q ? NumW'(-quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

endmodule
